// File: hw/rtl/gfwa_pkg.sv
// shared constants, register codes and types of the gated forward window average
`default_nettype none

package gfwa_pkg;

    // default sizes handed to the top level
    localparam int DEF_WINDOW_MAX  = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // configuration register field widths
    localparam int WS_W      = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MAX  = 2'd2;

    // status of the iterative divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gfwa_ifs.sv
// item channels and configuration write channel of the window average
`default_nettype none

interface gfwa_in_if import gfwa_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          sample_valid;
    logic                          last_in;

    modport source (output valid, output sample_value, output sample_valid,
                    output last_in, input ready);
    modport sink   (input valid, input sample_value, input sample_valid,
                    input last_in, output ready);
endinterface

interface gfwa_out_if import gfwa_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] average_value;
    logic                          average_valid;
    logic                          last_out;

    modport source (output valid, output average_value, output average_valid,
                    output last_out, input ready);
    modport sink   (input valid, input average_value, input average_valid,
                    input last_out, output ready);
endinterface

interface gfwa_cfg_if import gfwa_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [VALUE_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gated_forward_window_average.sv
// top level: configuration registers, window sequencer and output register
// results leave window_size - 1 items after their position; each result passes through the
//   check state, the ring reads, the divider (skipped for an empty window) and the output
//   register, where output stalls can hold it
// items are taken one at a time, a new one only once the sequencer is back in idle
// reset: rst_n clears sequencer, counters and output valid flag at once; no ring clearing pass
`default_nettype none

module gated_forward_window_average import gfwa_pkg::*; #(
    parameter int WINDOW_MAX  = DEF_WINDOW_MAX,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input wire logic       clk,
    input wire logic       rst_n,
    gfwa_cfg_if.sink       cfg,
    gfwa_in_if.sink        sample_in,
    gfwa_out_if.source     average_out
);

    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AW      = CNT_W + 1;
    localparam int SUM_W   = VALUE_WIDTH + CNT_W;
    localparam int ENTRY_W = VALUE_WIDTH + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_ACC   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    // configuration registers
    logic        [WS_W-1:0]        ws_reg;
    logic signed [VALUE_WIDTH-1:0] cmin_reg;
    logic signed [VALUE_WIDTH-1:0] cmax_reg;

    // sequencer state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       stored_reg, stored_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic                   flush_reg, flush_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic                   pend_reg, pend_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] avg_reg, avg_next;
    logic                          avgv_reg, avgv_next;
    logic                          lastf_reg, lastf_next;

    // ring and divider connections
    logic                   ring_we;
    logic                   ring_re;
    logic [ENTRY_W-1:0]     ring_rdata;
    logic [AW-1:0]          rd_addr;
    logic                   div_start;
    logic signed [VALUE_WIDTH-1:0] div_q;
    div_stat_t              div_stat;

    logic [CNT_W-1:0]       win;
    logic [AW-1:0]          wp_ext, st_ext, oldest, idx, addr_sum;
    logic                   slot_free;
    logic signed [VALUE_WIDTH-1:0] rd_value;
    logic                   rd_hit;

    // effective window: zero acts as one, clamp to the ring depth
    always_comb
    begin
        if (ws_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (32'(ws_reg) > WINDOW_MAX)
        begin
            win = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win = CNT_W'(ws_reg);
        end
    end

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= WS_W'(1);
            cmin_reg <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            cmax_reg <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_SIZE: ws_reg   <= cfg.data[WS_W-1:0];
                REG_CUTOFF_MIN:  cmin_reg <= signed'(cfg.data);
                REG_CUTOFF_MAX:  cmax_reg <= signed'(cfg.data);
                default:         ;
            endcase
        end
    end

    // ring address of window entry pos + j, clamped to the newest entry
    always_comb
    begin
        wp_ext = AW'(wp_reg);
        st_ext = AW'(stored_reg);
        if (wp_ext >= st_ext)
        begin
            oldest = wp_ext - st_ext;
        end
        else
        begin
            oldest = wp_ext + AW'(WINDOW_MAX) - st_ext;
        end
        idx = AW'(pos_reg) + AW'(j_reg);
        if (idx > st_ext - AW'(1))
        begin
            idx = st_ext - AW'(1);
        end
        addr_sum = oldest + idx;
        if (addr_sum >= AW'(WINDOW_MAX))
        begin
            rd_addr = addr_sum - AW'(WINDOW_MAX);
        end
        else
        begin
            rd_addr = addr_sum;
        end
    end

    // range gate on the entry read last cycle
    assign rd_value = signed'(ring_rdata[VALUE_WIDTH-1:0]);
    assign rd_hit   = ring_rdata[VALUE_WIDTH] && (rd_value >= cmin_reg)
                      && (rd_value <= cmax_reg);

    assign slot_free = !out_valid_reg || average_out.ready;

    // window sequencer
    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        wp_next        = wp_reg;
        flush_next     = flush_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        hits_next      = hits_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        avgv_next      = avgv_reg;
        lastf_next     = lastf_reg;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && average_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_in.valid)
                begin
                    ring_we     = 1'b1;
                    stored_next = stored_reg + CNT_W'(1);
                    flush_next  = sample_in.last_in;
                    pos_next    = '0;
                    if (AW'(wp_reg) + AW'(1) == AW'(WINDOW_MAX))
                    begin
                        wp_next = '0;
                    end
                    else
                    begin
                        wp_next = wp_reg + PTR_W'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flush_reg ? (pos_reg < stored_reg) : (stored_reg >= win))
                begin
                    j_next     = '0;
                    pend_next  = 1'b0;
                    sum_next   = '0;
                    hits_next  = '0;
                    state_next = S_ACC;
                end
                else
                begin
                    if (flush_reg)
                    begin
                        stored_next = '0;
                        wp_next     = '0;
                        flush_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ACC:
            begin
                pend_next = 1'b0;
                if (j_reg < win)
                begin
                    ring_re   = 1'b1;
                    j_next    = j_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && rd_hit)
                begin
                    sum_next  = sum_reg + signed'({{CNT_W{rd_value[VALUE_WIDTH-1]}}, rd_value});
                    hits_next = hits_reg + CNT_W'(1);
                end
                if ((j_reg == win) && !pend_reg)
                begin
                    if (hits_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    avgv_next      = hits_reg != '0;
                    avg_next       = (hits_reg != '0) ? div_q : '0;
                    lastf_next     = flush_reg && (AW'(pos_reg) + AW'(1) == st_ext);
                    if (flush_reg)
                    begin
                        pos_next = pos_reg + CNT_W'(1);
                    end
                    else
                    begin
                        stored_next = stored_reg - CNT_W'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stored_reg    <= '0;
            wp_reg        <= '0;
            flush_reg     <= 1'b0;
            pos_reg       <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            wp_reg        <= wp_next;
            flush_reg     <= flush_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        avg_reg   <= avg_next;
        avgv_reg  <= avgv_next;
        lastf_reg <= lastf_next;
    end

    // handshake outputs
    assign sample_in.ready           = state_reg == S_IDLE;
    assign average_out.valid         = out_valid_reg;
    assign average_out.average_value = avg_reg;
    assign average_out.average_valid = avgv_reg;
    assign average_out.last_out      = lastf_reg;

    gfwa_ring #(
        .DEPTH   (WINDOW_MAX),
        .ADDR_W  (PTR_W),
        .ENTRY_W (ENTRY_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata ({sample_in.sample_valid, sample_in.sample_value}),
        .re    (ring_re),
        .raddr (rd_addr[PTR_W-1:0]),
        .rdata (ring_rdata)
    );

    gfwa_div #(
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (hits_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // the divider is never restarted while it works
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished quotient only arrives while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result outside the wait state");

    // ring reads stay inside the ring
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_re |-> (rd_addr < AW'(WINDOW_MAX)) && (stored_reg != '0))
        else $error("ring read outside the stored entries");

    // pending positions never exceed the ring depth
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stored_reg) <= WINDOW_MAX)
        else $error("pending count above ring depth");

endmodule

`default_nettype wire

// File: hw/rtl/gfwa_ring.sv
// sample ring memory, one write and one registered read port
`default_nettype none

module gfwa_ring #(
    parameter int DEPTH   = 32,
    parameter int ADDR_W  = 5,
    parameter int ENTRY_W = 33
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [ENTRY_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered: data in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gfwa_div.sv
// iterative signed by unsigned divider, one quotient bit per cycle, truncating
`default_nettype none

module gfwa_div import gfwa_pkg::*; #(
    parameter int SUM_W       = 38,
    parameter int CNT_W       = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [SUM_W-1:0]       dividend,
    input  wire logic        [CNT_W-1:0]       divisor,
    output logic signed      [VALUE_WIDTH-1:0] quotient,
    output div_stat_t                          stat
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg,  neg_next;
    logic [SUM_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]  dvs_reg,  dvs_next;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              fits;
    logic [VALUE_WIDTH-1:0] mag;

    // one restoring step
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // magnitude fits the value width, sign restored on the way out
    assign mag      = quo_reg[VALUE_WIDTH-1:0];
    assign quotient = neg_reg ? signed'(-mag) : signed'(mag);
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench of the gated forward window average
`timescale 1ns / 100ps

module testbench;
    import gfwa_pkg::*;

    localparam int VW            = DEF_VALUE_WIDTH;
    localparam int WMAX          = DEF_WINDOW_MAX;
    localparam int HALF_PERIOD   = 10;
    localparam int RANDOM_ITEMS  = 230;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 32;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct packed {
        logic signed [VW-1:0] avg;
        logic                 avg_ok;
        logic                 is_last;
    } mean_result_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [VW-1:0]        word;
        logic                 present;
        logic                 last;
        logic                 typed;
        logic signed [VW-1:0] want_avg;
        logic                 want_ok;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gfwa_in_if  #(.VALUE_WIDTH(VW)) sample_ch ();
    gfwa_out_if #(.VALUE_WIDTH(VW)) result_ch ();
    gfwa_cfg_if #(.VALUE_WIDTH(VW)) cfg_ch ();

    gated_forward_window_average #(
        .WINDOW_MAX  (WMAX),
        .VALUE_WIDTH (VW)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .sample_in   (sample_ch),
        .average_out (result_ch)
    );

    // own copy of the window state and registers
    logic signed [VW-1:0] ring_value [WMAX];
    logic                 ring_present [WMAX];
    int unsigned          pending_n;
    int unsigned          wr_slot;
    logic [WS_W-1:0]      win_reg;
    logic signed [VW-1:0] lo_cut;
    logic signed [VW-1:0] hi_cut;

    mean_result_t expected_avgs[$];
    stim_row_t    directed_rows[$];
    int           fail_count = 0;
    bit           in_gaps    = 1'b1;
    bit           out_stalls = 1'b1;

    // clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // window size as the block applies it
    function automatic int unsigned applied_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > WMAX)
            return WMAX;
        return win_reg;
    endfunction

    // gated mean of the window starting at pending position pos, newest entry repeated
    function automatic mean_result_t window_mean(input int unsigned pos, input int unsigned win,
                                                 input logic last);
        longint       total;
        longint       quot;
        int unsigned  hits;
        int unsigned  first;
        int unsigned  idx;
        int unsigned  slot;
        mean_result_t r;
        total = 0;
        hits  = 0;
        first = (wr_slot + WMAX - pending_n) % WMAX;
        for (int unsigned j = 0; j < win; j++)
        begin
            idx = pos + j;
            if (idx > pending_n - 1)
                idx = pending_n - 1;
            slot = (first + idx) % WMAX;
            if (ring_present[slot] && ring_value[slot] >= lo_cut && ring_value[slot] <= hi_cut)
            begin
                total += ring_value[slot];
                hits++;
            end
        end
        if (hits > 0)
        begin
            quot     = total / longint'(hits);
            r.avg    = quot[VW-1:0];
            r.avg_ok = 1'b1;
        end
        else
        begin
            r.avg    = '0;
            r.avg_ok = 1'b0;
        end
        r.is_last = last;
        return r;
    endfunction

    // advance the window state by one item, queueing the averages it releases
    function automatic void predict_sample(input logic signed [VW-1:0] v, input logic present,
                                           input logic last, input bit keep);
        int unsigned  win;
        mean_result_t r;
        win                   = applied_window();
        ring_value[wr_slot]   = v;
        ring_present[wr_slot] = present;
        wr_slot               = (wr_slot + 1) % WMAX;
        pending_n++;
        if (last)
        begin
            for (int unsigned k = 0; k < pending_n; k++)
            begin
                r = window_mean(k, win, k == pending_n - 1);
                if (keep)
                    expected_avgs.insert(expected_avgs.size(), r);
            end
            pending_n = 0;
            wr_slot   = 0;
        end
        else
        begin
            while (pending_n >= win)
            begin
                r = window_mean(0, win, 1'b0);
                if (keep)
                    expected_avgs.insert(expected_avgs.size(), r);
                pending_n--;
            end
        end
    endfunction

    function automatic stim_row_t smp_row(input logic [VW-1:0] word, input logic present,
                                          input logic last);
        stim_row_t r;
        r.kind     = ROW_SAMPLE;
        r.reg_idx  = REG_WINDOW_SIZE;
        r.word     = word;
        r.present  = present;
        r.last     = last;
        r.typed    = 1'b0;
        r.want_avg = '0;
        r.want_ok  = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [VW-1:0] word, input logic present,
                                            input logic last, input logic [VW-1:0] want_avg,
                                            input logic want_ok);
        stim_row_t r;
        r          = smp_row(word, present, last);
        r.typed    = 1'b1;
        r.want_avg = want_avg;
        r.want_ok  = want_ok;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [VW-1:0] word);
        stim_row_t r;
        r         = smp_row(word, 1'b0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        return r;
    endfunction

    // offer one item, with random idle cycles first, and predict it once taken
    task automatic send_sample(input logic [VW-1:0] word, input logic present,
                               input logic last, input bit keep);
        cfg_ch.valid <= 1'b0;
        while (in_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= word;
        sample_ch.sample_valid <= present;
        sample_ch.last_in      <= last;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_sample(word, present, last, keep);
    endtask

    // hold off until every expected average is in and the block has settled
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [VW-1:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_WINDOW_SIZE: win_reg = word[WS_W-1:0];
            REG_CUTOFF_MIN:  lo_cut  = word;
            REG_CUTOFF_MAX:  hi_cut  = word;
            default: ;
        endcase
    endtask

    // result side: random back-pressure and comparison with the oldest expectation
    always @(posedge clk)
    begin
        mean_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_avgs.size() == 0)
            begin
                $error("average with none expected: value %0d valid %0b last %0b",
                       result_ch.average_value, result_ch.average_valid, result_ch.last_out);
                fail_count++;
            end
            else
            begin
                want = expected_avgs.pop_front();
                if (result_ch.average_value !== want.avg)
                begin
                    $error("average_value: expected %0d, got %0d",
                           want.avg, result_ch.average_value);
                    fail_count++;
                end
                if (result_ch.average_valid !== want.avg_ok)
                begin
                    $error("average_valid: expected %0b, got %0b",
                           want.avg_ok, result_ch.average_valid);
                    fail_count++;
                end
                if (result_ch.last_out !== want.is_last)
                begin
                    $error("last_out: expected %0b, got %0b", want.is_last, result_ch.last_out);
                    fail_count++;
                end
            end
        end
        result_ch.ready <= !out_stalls || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // stimulus
    initial
    begin
        stim_row_t        row;
        mean_result_t     typed_want;
        int               random_sent;
        int               series_no;
        int               len;
        int               waited;
        bit               broken;
        bit               quiet;
        logic [VW-1:0]    word;
        logic [VW-1:0]    lo_word;
        logic [VW-1:0]    hi_word;
        logic [WS_W-1:0]  ws;

        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.sample_valid <= 1'b0;
        sample_ch.last_in      <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_WINDOW_SIZE;
        cfg_ch.data            <= '0;

        // register values after reset
        win_reg   = WS_W'(1);
        lo_cut    = 32'h8000_0000;
        hi_cut    = 32'h7FFF_FFFF;
        pending_n = 0;
        wr_slot   = 0;

        directed_rows = '{
            // window of one, full range: each item gives its own average
            typed_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1),
            typed_row(32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000, 1'b1),
            typed_row(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0),
            typed_row(32'h0001_2345, 1'b1, 1'b1, 32'h0001_2345, 1'b1),
            typed_row(32'h5555_AAAA, 1'b0, 1'b1, 32'h0000_0000, 1'b0),
            // gate of 1.0 to 2.0, bounds counted
            reg_row(REG_CUTOFF_MIN, 32'h0001_0000),
            reg_row(REG_CUTOFF_MAX, 32'h0002_0000),
            typed_row(32'h0000_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0),
            typed_row(32'h0001_0000, 1'b1, 1'b0, 32'h0001_0000, 1'b1),
            typed_row(32'h0002_0000, 1'b1, 1'b0, 32'h0002_0000, 1'b1),
            typed_row(32'h0002_0001, 1'b1, 1'b1, 32'h0000_0000, 1'b0),
            // inverted gate lets nothing through
            reg_row(REG_CUTOFF_MIN, 32'h0000_0005),
            reg_row(REG_CUTOFF_MAX, 32'hFFFF_FFFB),
            typed_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0),
            // window of four over extreme values, flushed by an absent last item
            reg_row(REG_CUTOFF_MIN, 32'h8000_0000),
            reg_row(REG_CUTOFF_MAX, 32'h7FFF_FFFF),
            reg_row(REG_WINDOW_SIZE, 32'd4),
            smp_row(32'h7FFF_FFFF, 1'b1, 1'b0),
            smp_row(32'h7FFF_FFFF, 1'b1, 1'b0),
            smp_row(32'h7FFF_FFFF, 1'b1, 1'b0),
            smp_row(32'h7FFF_FFFF, 1'b1, 1'b0),
            smp_row(32'h8000_0000, 1'b1, 1'b0),
            smp_row(32'h0000_0000, 1'b0, 1'b1),
            // zero window size behaves as one
            reg_row(REG_WINDOW_SIZE, 32'd0),
            typed_row(32'h0000_0007, 1'b1, 1'b1, 32'h0000_0007, 1'b1),
            // oversize window clamps, negative means truncate toward zero
            reg_row(REG_WINDOW_SIZE, 32'd63),
            smp_row(32'hFFFF_FFFF, 1'b1, 1'b0),
            smp_row(32'hFFFF_FFFE, 1'b1, 1'b1),
            // window shrunk with positions pending, then grown again
            reg_row(REG_WINDOW_SIZE, 32'd8),
            smp_row(32'd10, 1'b1, 1'b0),
            smp_row(32'd20, 1'b0, 1'b0),
            smp_row(32'd30, 1'b1, 1'b0),
            smp_row(32'd40, 1'b1, 1'b0),
            reg_row(REG_WINDOW_SIZE, 32'd2),
            smp_row(32'd50, 1'b1, 1'b0),
            reg_row(REG_WINDOW_SIZE, 32'd5),
            smp_row(32'd60, 1'b1, 1'b0),
            smp_row(32'd70, 1'b1, 1'b1)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_until_idle();
                write_register(row.reg_idx, row.word);
            end
            else if (row.typed)
            begin
                typed_want.avg     = row.want_avg;
                typed_want.avg_ok  = row.want_ok;
                typed_want.is_last = row.last;
                expected_avgs.insert(expected_avgs.size(), typed_want);
                send_sample(row.word, row.present, row.last, 1'b0);
            end
            else
            begin
                send_sample(row.word, row.present, row.last, 1'b1);
            end
        end

        // random series, some cut short so settings change with positions pending
        random_sent = 0;
        series_no   = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            series_no++;
            quiet      = (series_no >= 8 && series_no < 16);
            in_gaps    = !quiet;
            out_stalls = !quiet;

            // new settings between series
            if ($urandom_range(2) == 0)
            begin
                wait_until_idle();
                case ($urandom_range(7))
                    0:       ws = WS_W'(1);
                    1:       ws = WS_W'(WMAX);
                    2:       ws = '0;
                    3:       ws = WS_W'($urandom_range(WMAX + 1, 63));
                    default: ws = WS_W'($urandom_range(2, 8));
                endcase
                case ($urandom_range(3))
                    0:
                    begin
                        lo_word = 32'h8000_0000;
                        hi_word = 32'h7FFF_FFFF;
                    end
                    1:
                    begin
                        lo_word = -$urandom_range(0, 32'h4_0000);
                        hi_word = $urandom_range(0, 32'h4_0000);
                    end
                    2:
                    begin
                        lo_word = $urandom;
                        hi_word = $urandom;
                    end
                    default:
                    begin
                        lo_word = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
                        hi_word = 32'h7FFF_FFFF;
                    end
                endcase
                if ($urandom_range(2) != 0)
                    write_register(REG_WINDOW_SIZE, ($urandom & ~32'h3F) | ws);
                if ($urandom_range(2) != 0)
                    write_register(REG_CUTOFF_MIN, lo_word);
                if ($urandom_range(2) != 0)
                    write_register(REG_CUTOFF_MAX, hi_word);
            end

            if ($urandom_range(4) == 0)
                len = $urandom_range(13, 45);
            else
                len = $urandom_range(1, 12);
            broken = ($urandom_range(5) == 0);

            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(7))
                    0:       word = 32'h7FFF_FFFF;
                    1:       word = 32'h8000_0000;
                    2, 3:    word = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
                    default: word = $urandom;
                endcase
                send_sample(word, $urandom_range(7) != 0, (k == len - 1) && !broken, 1'b1);
                random_sent++;
            end

            // sender holds off until everything owed has come back
            if ($urandom_range(4) == 0)
                wait_until_idle();
        end

        // drain
        sample_ch.valid <= 1'b0;
        waited = 0;
        while (expected_avgs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_avgs.size() != 0)
        begin
            $error("%0d expected averages never arrived", expected_avgs.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
